// ===== hw/rtl/gti_pkg.sv =====
package gti_pkg;

    // angle format: degrees * 2^ANGLE_FRAC_BITS
    localparam int ANGLE_FRAC_BITS = 10;
    localparam int TABLE_FRAC      = 20;
    localparam int GAIN_FRAC       = 26;
    localparam int GAIN_SHIFT      = GAIN_FRAC - ANGLE_FRAC_BITS;
    localparam int ROLL_SHIFT      = TABLE_FRAC - ANGLE_FRAC_BITS;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_STEP_GAIN     = 2'd0;
    localparam logic [1:0] REG_CURSOR_GAIN   = 2'd1;
    localparam logic [1:0] REG_CURSOR_OFFSET = 2'd2;

    localparam logic [15:0] STEP_GAIN_RST     = 16'd5123;
    localparam logic [7:0]  CURSOR_GAIN_RST   = 8'd70;
    localparam logic [11:0] CURSOR_OFFSET_RST = 12'd750;

    localparam logic signed [20:0] ACC_MAX  = 21'sd360 <<< ANGLE_FRAC_BITS;
    localparam logic signed [19:0] ROLL_MAX = 20'sd180 <<< ANGLE_FRAC_BITS;
    localparam logic signed [29:0] Z_QUARTER = 30'sd90 <<< TABLE_FRAC;

    // multiplier operand select
    localparam logic [1:0] MUL_GY    = 2'd0;
    localparam logic [1:0] MUL_GZ    = 2'd1;
    localparam logic [1:0] MUL_PITCH = 2'd2;
    localparam logic [1:0] MUL_YAW   = 2'd3;

    typedef struct packed {
        logic [15:0] step_gain;
        logic [7:0]  cursor_gain;
        logic [11:0] cursor_offset;
    } gti_cfg_t;

    typedef struct packed {
        logic       start;
        logic       step;
        logic [4:0] iter;
        logic [1:0] mul_sel;
        logic       acc_pitch;
        logic       acc_yaw;
        logic       cur_y;
        logic       cur_x;
        logic       load_out;
    } gti_cmd_t;

    // atan(2^-i) in degrees * 2^20
    function automatic logic signed [29:0] atan_q20(input logic [4:0] idx);
        logic signed [29:0] v;
        case (idx)
            5'd0:    v = 30'sd47185920;
            5'd1:    v = 30'sd27855475;
            5'd2:    v = 30'sd14718068;
            5'd3:    v = 30'sd7471121;
            5'd4:    v = 30'sd3750058;
            5'd5:    v = 30'sd1876857;
            5'd6:    v = 30'sd938658;
            5'd7:    v = 30'sd469357;
            5'd8:    v = 30'sd234682;
            5'd9:    v = 30'sd117342;
            5'd10:   v = 30'sd58671;
            5'd11:   v = 30'sd29335;
            5'd12:   v = 30'sd14668;
            5'd13:   v = 30'sd7334;
            5'd14:   v = 30'sd3667;
            5'd15:   v = 30'sd1833;
            5'd16:   v = 30'sd917;
            5'd17:   v = 30'sd458;
            5'd18:   v = 30'sd229;
            5'd19:   v = 30'sd115;
            5'd20:   v = 30'sd57;
            5'd21:   v = 30'sd29;
            5'd22:   v = 30'sd14;
            5'd23:   v = 30'sd7;
            default: v = 30'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/gti_if.sv =====
interface gti_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;

    modport source (output valid, accel_y, accel_z, gyro_y, gyro_z, input ready);
    modport sink (input valid, accel_y, accel_z, gyro_y, gyro_z, output ready);
endinterface

interface gti_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] roll_angle;
    logic signed [19:0] pitch_angle;
    logic signed [19:0] yaw_angle;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, cursor_x, cursor_y,
                    input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, cursor_x, cursor_y,
                  output ready);
endinterface

// ===== hw/rtl/gti_regs.sv =====
module gti_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gti_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gti_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gti_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output gti_pkg::gti_cfg_t                  cfg
);

    logic [15:0] step_gain_reg;
    logic [7:0]  cursor_gain_reg;
    logic [11:0] cursor_offset_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg     <= gti_pkg::STEP_GAIN_RST;
            cursor_gain_reg   <= gti_pkg::CURSOR_GAIN_RST;
            cursor_offset_reg <= gti_pkg::CURSOR_OFFSET_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                gti_pkg::REG_STEP_GAIN:     step_gain_reg     <= pwdata[15:0];
                gti_pkg::REG_CURSOR_GAIN:   cursor_gain_reg   <= pwdata[7:0];
                gti_pkg::REG_CURSOR_OFFSET: cursor_offset_reg <= pwdata[11:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gti_pkg::REG_STEP_GAIN:     prdata = {16'd0, step_gain_reg};
            gti_pkg::REG_CURSOR_GAIN:   prdata = {24'd0, cursor_gain_reg};
            gti_pkg::REG_CURSOR_OFFSET: prdata = {20'd0, cursor_offset_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.step_gain     = step_gain_reg;
    assign cfg.cursor_gain   = cursor_gain_reg;
    assign cfg.cursor_offset = cursor_offset_reg;

endmodule

// ===== hw/rtl/gti_ctrl.sv =====
module gti_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gti_pkg::gti_cmd_t cmd
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             slot_free;
    logic             in_rot;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_rot    = (state_reg == S_ROT);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ROT;
                    cnt_next   = '0;
                end
            end
            S_ROT:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // multiplies ride along the first cordic iterations
    always_comb
    begin
        cmd.start     = accept;
        cmd.step      = in_rot;
        cmd.iter      = 5'(cnt_reg);
        cmd.acc_pitch = in_rot && (cnt_reg == CNT_W'(1));
        cmd.acc_yaw   = in_rot && (cnt_reg == CNT_W'(2));
        cmd.cur_y     = in_rot && (cnt_reg == CNT_W'(3));
        cmd.cur_x     = in_rot && (cnt_reg == CNT_W'(4));
        cmd.load_out  = (state_reg == S_DONE) && slot_free;
        case (cnt_reg)
            CNT_W'(1): cmd.mul_sel = gti_pkg::MUL_GZ;
            CNT_W'(2): cmd.mul_sel = gti_pkg::MUL_PITCH;
            CNT_W'(3): cmd.mul_sel = gti_pkg::MUL_YAW;
            default:   cmd.mul_sel = gti_pkg::MUL_GY;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_start_rot: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ROT) && (cnt_reg == '0))
        else $error("accepted sample did not start the rotation");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("finished item left done state while output stalled");
`endif

endmodule

// ===== hw/rtl/gti_datapath.sv =====
module gti_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gti_pkg::gti_cmd_t  cmd,
    input  gti_pkg::gti_cfg_t  cfg,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    output logic signed [18:0] roll_angle,
    output logic signed [19:0] pitch_angle,
    output logic signed [19:0] yaw_angle,
    output logic signed [15:0] cursor_x,
    output logic signed [15:0] cursor_y
);

    // cordic vector and angle
    logic signed [26:0] x_reg, y_reg;
    logic signed [29:0] z_reg;
    logic               zero_reg;
    logic signed [15:0] gy_reg, gz_reg;

    logic signed [36:0] prod_reg;
    logic signed [19:0] pitch_sum_reg, yaw_sum_reg;
    logic signed [15:0] cur_x_reg, cur_y_reg;

    logic signed [18:0] roll_q_reg;
    logic signed [19:0] pitch_q_reg, yaw_q_reg;
    logic signed [15:0] cur_x_q_reg, cur_y_q_reg;

    logic signed [26:0] x_in, y_in, x_init, y_init;
    logic signed [29:0] z_init;
    logic signed [26:0] dx, dy;
    logic signed [29:0] atan_v;

    logic signed [19:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [36:0] prod_next;

    logic signed [33:0] inc_wide;
    logic signed [17:0] inc;
    logic signed [19:0] acc_base;
    logic signed [20:0] acc_sum;
    logic signed [19:0] acc_res;

    logic signed [28:0] cur_prod;
    logic signed [28:0] cur_bias;
    logic signed [18:0] cur_trunc;
    logic signed [19:0] cur_sum;
    logic signed [15:0] cur_sat;

    logic signed [29:0] z_round;
    logic signed [19:0] z_deg;
    logic signed [18:0] roll_val;

    // pre-rotation into the right half plane
    always_comb
    begin
        x_in = {{3{accel_z[15]}}, accel_z, 8'h00};
        y_in = {{3{accel_y[15]}}, accel_y, 8'h00};
        x_init = x_in;
        y_init = y_in;
        z_init = '0;
        if (x_in[26])
        begin
            if (!y_in[26])
            begin
                x_init = y_in;
                y_init = -x_in;
                z_init = gti_pkg::Z_QUARTER;
            end
            else
            begin
                x_init = -y_in;
                y_init = x_in;
                z_init = -gti_pkg::Z_QUARTER;
            end
        end
    end

    assign dx     = y_reg >>> cmd.iter;
    assign dy     = x_reg >>> cmd.iter;
    assign atan_v = gti_pkg::atan_q20(cmd.iter);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            z_reg    <= z_init;
            zero_reg <= (accel_y == 16'sd0) && (accel_z == 16'sd0);
            gy_reg   <= gyro_y;
            gz_reg   <= gyro_z;
        end
        else if (cmd.step)
        begin
            if (!y_reg[26])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_v;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_v;
            end
        end
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            gti_pkg::MUL_GY:
            begin
                mul_a = 20'(gy_reg);
                mul_b = {1'b0, cfg.step_gain};
            end
            gti_pkg::MUL_GZ:
            begin
                mul_a = 20'(gz_reg);
                mul_b = {1'b0, cfg.step_gain};
            end
            gti_pkg::MUL_PITCH:
            begin
                mul_a = pitch_sum_reg;
                mul_b = {9'd0, cfg.cursor_gain};
            end
            gti_pkg::MUL_YAW:
            begin
                mul_a = yaw_sum_reg;
                mul_b = {9'd0, cfg.cursor_gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // increment rounded half up, wrap above +360, clamp below -360
    always_comb
    begin
        inc_wide = 34'($signed(prod_reg[32:0])) + (34'sd1 <<< (gti_pkg::GAIN_SHIFT - 1));
        inc      = 18'(inc_wide >>> gti_pkg::GAIN_SHIFT);
        acc_base = cmd.acc_pitch ? pitch_sum_reg : yaw_sum_reg;
        acc_sum  = 21'(acc_base) + 21'(inc);
        if (acc_sum > gti_pkg::ACC_MAX)
            acc_res = 20'(acc_sum - gti_pkg::ACC_MAX);
        else if (acc_sum < -gti_pkg::ACC_MAX)
            acc_res = 20'(-gti_pkg::ACC_MAX);
        else
            acc_res = 20'(acc_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_sum_reg <= '0;
            yaw_sum_reg   <= '0;
        end
        else
        begin
            if (cmd.acc_pitch)
                pitch_sum_reg <= acc_res;
            if (cmd.acc_yaw)
                yaw_sum_reg <= acc_res;
        end
    end

    // cursor: truncate toward zero, add offset, saturate
    always_comb
    begin
        cur_prod  = prod_reg[28:0];
        cur_bias  = cur_prod[28] ? 29'sd1023 : 29'sd0;
        cur_trunc = 19'((cur_prod + cur_bias) >>> gti_pkg::ANGLE_FRAC_BITS);
        cur_sum   = 20'(cur_trunc) + 20'($signed({8'd0, cfg.cursor_offset}));
        if (cur_sum > 20'sd32767)
            cur_sat = 16'sh7fff;
        else if (cur_sum < -20'sd32768)
            cur_sat = 16'sh8000;
        else
            cur_sat = 16'(cur_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_y)
            cur_y_reg <= cur_sat;
        if (cmd.cur_x)
            cur_x_reg <= cur_sat;
    end

    // roll: round half up, clamp to +-180
    always_comb
    begin
        z_round = z_reg + (30'sd1 <<< (gti_pkg::ROLL_SHIFT - 1));
        z_deg   = 20'(z_round >>> gti_pkg::ROLL_SHIFT);
        if (zero_reg)
            roll_val = '0;
        else if (z_deg > gti_pkg::ROLL_MAX)
            roll_val = 19'(gti_pkg::ROLL_MAX);
        else if (z_deg < -gti_pkg::ROLL_MAX)
            roll_val = 19'(-gti_pkg::ROLL_MAX);
        else
            roll_val = 19'(z_deg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            roll_q_reg  <= roll_val;
            pitch_q_reg <= pitch_sum_reg;
            yaw_q_reg   <= yaw_sum_reg;
            cur_x_q_reg <= cur_x_reg;
            cur_y_q_reg <= cur_y_reg;
        end
    end

    assign roll_angle  = roll_q_reg;
    assign pitch_angle = pitch_q_reg;
    assign yaw_angle   = yaw_q_reg;
    assign cursor_x    = cur_x_q_reg;
    assign cursor_y    = cur_y_q_reg;

`ifndef SYNTH
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_pitch |=> (pitch_sum_reg <= 20'sd368640) && (pitch_sum_reg >= -20'sd368640)
                          && $stable(yaw_sum_reg))
        else $error("pitch update out of range or disturbed yaw");

    a_zero_roll: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && zero_reg) |=> (roll_q_reg == 19'sd0))
        else $error("zero accelerometer vector gave nonzero roll");
`endif

endmodule

// ===== hw/rtl/gyro_tilt_integrator.sv =====
// gyro_tilt_integrator: roll from the accelerometer, pitch/yaw from the gyro
// sample channel (valid/ready): accel_y, accel_z, gyro_y, gyro_z, 16-bit signed
// result channel (valid/ready): roll, pitch, yaw (1/1024 degree), cursor x/y
// apb port: step_gain at 0x0, cursor_gain at 0x4, cursor_offset at 0x8
// one result per sample, in order
// a sample transfer starts the iterative cordic; when the rotation state ends,
// the done state loads the result into the output register once it is free
// a new sample is taken only in the idle state, after the last one has left
// the done state, so the sample rate is set by the cordic loop, which does
// one micro-rotation per cycle on a single shift/add unit
// the gyro and cursor multiplies share one multiplier during that loop
// the output register lets the next sample be taken while a result waits;
// if the receiver stalls, the finished item waits in the done state and no
// further sample is taken until the output register frees up
// reset clears the pitch/yaw accumulators, restores register defaults and
// empties the output register
module gyro_tilt_integrator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gti_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gti_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gti_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    gti_in_if.sink                         sample,
    gti_out_if.source                      result
);

    gti_pkg::gti_cfg_t cfg;
    gti_pkg::gti_cmd_t cmd;

    // configuration registers
    gti_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accept, iterate, hand off to the output register
    gti_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // cordic, accumulators, cursor scaling and output register
    gti_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .gyro_y      (sample.gyro_y),
        .gyro_z      (sample.gyro_z),
        .roll_angle  (result.roll_angle),
        .pitch_angle (result.pitch_angle),
        .yaw_angle   (result.yaw_angle),
        .cursor_x    (result.cursor_x),
        .cursor_y    (result.cursor_y)
    );

endmodule

// ===== verif/tilt_monitor.sv =====
`timescale 1ns / 100ps

module tilt_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [gti_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gti_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [gti_pkg::APB_DATA_W-1:0] prdata,
    gti_in_if                              sample,
    gti_out_if                             result,
    output int                             mismatches,
    output int                             outstanding
);

    localparam int     STEPS      = 16;
    localparam int     FRAC       = 10;
    localparam int     Q20_TO_Q   = 20 - FRAC;
    localparam int     GAIN_TO_Q  = 26 - FRAC;
    localparam longint FULL_TURN  = 64'sd360 <<< FRAC;
    localparam longint HALF_TURN  = 64'sd180 <<< FRAC;
    localparam longint RIGHT_Q20  = 64'sd90 <<< 20;
    localparam longint STEP_GAIN_DEF     = 5123;
    localparam longint CURSOR_GAIN_DEF   = 70;
    localparam longint CURSOR_OFFSET_DEF = 750;

    // atan(2^-i) in degrees * 2^20
    localparam longint ATAN_Q20 [0:23] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct {
        logic signed [18:0] roll;
        logic signed [19:0] pitch;
        logic signed [19:0] yaw;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } attitude_t;

    attitude_t attitude_q [$];
    attitude_t want;
    longint    step_gain;
    longint    cursor_gain;
    longint    cursor_offset;
    longint    pitch_total;
    longint    yaw_acc;
    longint    reg_want;
    bit        reg_known;

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            flag($sformatf("%s mismatch: expected %0d, got %0d", name, exp_v, got_v));
        end
    endtask

    function automatic longint roll_deg(input longint ay, input longint az);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint dx;
        longint dy;
        int     i;
        if (ay == 0 && az == 0)
        begin
            return 0;
        end
        x = az * 256;
        y = ay * 256;
        z = 0;
        // left half plane: quarter turn first
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y;
                y  = -x;
                x  = nx;
                z  = RIGHT_Q20;
            end
            else
            begin
                nx = -y;
                y  = x;
                x  = nx;
                z  = -RIGHT_Q20;
            end
        end
        for (i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q20[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q20[i];
            end
        end
        z = (z + (64'sd1 <<< (Q20_TO_Q - 1))) >>> Q20_TO_Q;
        if (z > HALF_TURN)
        begin
            z = HALF_TURN;
        end
        if (z < -HALF_TURN)
        begin
            z = -HALF_TURN;
        end
        return z;
    endfunction

    function automatic longint integrate_rate(input longint acc, input longint rate);
        longint inc;
        inc = (rate * step_gain + (64'sd1 <<< (GAIN_TO_Q - 1))) >>> GAIN_TO_Q;
        acc = acc + inc;
        if (acc > FULL_TURN)
        begin
            acc = acc - FULL_TURN;
        end
        else if (acc < -FULL_TURN)
        begin
            acc = -FULL_TURN;
        end
        return acc;
    endfunction

    function automatic longint cursor_pos(input longint ang);
        longint p;
        longint t;
        p = ang * cursor_gain;
        t = (p >= 0) ? (p >>> FRAC) : -((-p) >>> FRAC);
        t = t + cursor_offset;
        if (t > 32767)
        begin
            t = 32767;
        end
        if (t < -32768)
        begin
            t = -32768;
        end
        return t;
    endfunction

    function automatic attitude_t next_attitude(input logic signed [15:0] ay,
                                                input logic signed [15:0] az,
                                                input logic signed [15:0] gy,
                                                input logic signed [15:0] gz);
        attitude_t a;
        pitch_total = integrate_rate(pitch_total, gy);
        yaw_acc     = integrate_rate(yaw_acc, gz);
        a.roll      = 19'(roll_deg(ay, az));
        a.pitch     = 20'(pitch_total);
        a.yaw       = 20'(yaw_acc);
        a.cx        = 16'(cursor_pos(yaw_acc));
        a.cy        = 16'(cursor_pos(pitch_total));
        return a;
    endfunction

    initial
    begin
        mismatches = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain     = STEP_GAIN_DEF;
            cursor_gain   = CURSOR_GAIN_DEF;
            cursor_offset = CURSOR_OFFSET_DEF;
            pitch_total   = 0;
            yaw_acc       = 0;
            attitude_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                reg_known = 1'b1;
                case (paddr[3:2])
                    gti_pkg::REG_STEP_GAIN:     reg_want = step_gain;
                    gti_pkg::REG_CURSOR_GAIN:   reg_want = cursor_gain;
                    gti_pkg::REG_CURSOR_OFFSET: reg_want = cursor_offset;
                    default:                    reg_known = 1'b0;
                endcase
                if (pwrite)
                begin
                    case (paddr[3:2])
                        gti_pkg::REG_STEP_GAIN:     step_gain     = longint'(pwdata[15:0]);
                        gti_pkg::REG_CURSOR_GAIN:   cursor_gain   = longint'(pwdata[7:0]);
                        gti_pkg::REG_CURSOR_OFFSET: cursor_offset = longint'(pwdata[11:0]);
                        default:                    ;
                    endcase
                end
                else if (reg_known)
                begin
                    check_field($sformatf("register %0d read", paddr[3:2]), reg_want,
                                longint'(prdata));
                end
            end
            if (sample.valid && sample.ready)
            begin
                attitude_q.push_back(next_attitude(sample.accel_y, sample.accel_z,
                                                   sample.gyro_y, sample.gyro_z));
            end
            if (result.valid && result.ready)
            begin
                if (attitude_q.size() == 0)
                begin
                    flag("result transfer with no sample outstanding");
                end
                else
                begin
                    want = attitude_q.pop_front();
                    check_field("roll_angle", want.roll, result.roll_angle);
                    check_field("pitch_angle", want.pitch, result.pitch_angle);
                    check_field("yaw_angle", want.yaw, result.yaw_angle);
                    check_field("cursor_x", want.cx, result.cursor_x);
                    check_field("cursor_y", want.cy, result.cursor_y);
                end
            end
            outstanding <= attitude_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // longest stretch with no transfer of any kind before giving up
    localparam int IDLE_LIMIT   = 2000;
    // cycles to watch for stray results once everything has drained
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 192;
    // an index past the register map, writes to it must be dropped
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gti_pkg::APB_ADDR_W-1:0] paddr;
    logic [gti_pkg::APB_DATA_W-1:0] pwdata;
    logic [gti_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    gti_in_if  sample_bus ();
    gti_out_if result_bus ();

    int mismatches;
    int outstanding;
    int idle_cycles;
    bit tx_steady;
    bit rx_steady;
    int drift_y;
    int drift_z;

    gyro_tilt_integrator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_bus),
        .result  (result_bus)
    );

    tilt_monitor tilt_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .sample      (sample_bus),
        .result      (result_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one apb access: setup phase, access phase until pready, then back to idle
    task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // program all three registers with junk in the unused upper bits,
    // poke the spare index, then read the map back
    task automatic set_registers(input logic [15:0] sg, input logic [7:0] cg,
                                 input logic [11:0] co);
        apb_access(gti_pkg::REG_STEP_GAIN, 1'b1, {16'($urandom), sg});
        apb_access(gti_pkg::REG_CURSOR_GAIN, 1'b1, {24'($urandom), cg});
        apb_access(gti_pkg::REG_CURSOR_OFFSET, 1'b1, {20'($urandom), co});
        apb_access(REG_SPARE, 1'b1, $urandom);
        apb_access(gti_pkg::REG_STEP_GAIN, 1'b0, '0);
        apb_access(gti_pkg::REG_CURSOR_GAIN, 1'b0, '0);
        apb_access(gti_pkg::REG_CURSOR_OFFSET, 1'b0, '0);
    endtask

    // one sample transfer, preceded by a random gap unless in a steady stretch
    task automatic send_sample(input logic signed [15:0] ay, input logic signed [15:0] az,
                               input logic signed [15:0] gy, input logic signed [15:0] gz);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.accel_y <= ay;
        sample_bus.accel_z <= az;
        sample_bus.gyro_y  <= gy;
        sample_bus.gyro_z  <= gz;
        @(posedge clk);
        while (!sample_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    // gyro rate: mostly pushing one way so the accumulators reach the
    // wrap and the negative clamp, sometimes tiny, sometimes anything at all
    function automatic logic signed [15:0] rate_draw(input int drift);
        logic [14:0] mag;
        mag = 15'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    return 16'($urandom);
            2:       return 16'(int'($urandom_range(0, 6)) - 3);
            default: return (drift > 0) ? {1'b0, mag} : {1'b1, ~mag};
        endcase
    endfunction

    task automatic random_sample();
        logic signed [15:0] ay;
        logic signed [15:0] az;
        ay = 16'($urandom);
        az = 16'($urandom);
        // accelerometer: origin, the axes and tiny vectors now and then
        case ($urandom_range(0, 9))
            0:
            begin
                ay = '0;
                az = '0;
            end
            1:       ay = '0;
            2:       az = '0;
            3:
            begin
                ay = 16'(int'($urandom_range(0, 8)) - 4);
                az = 16'(int'($urandom_range(0, 8)) - 4);
            end
            default: ;
        endcase
        if ($urandom_range(0, 59) == 0)
        begin
            drift_y = -drift_y;
        end
        if ($urandom_range(0, 59) == 0)
        begin
            drift_z = -drift_z;
        end
        send_sample(ay, az, rate_draw(drift_y), rate_draw(drift_z));
    endtask

    // stop offering samples and wait until every result has come back
    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side: random stall before each transfer, with steady stretches
    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rx_steady = !rx_steady;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
            while (!result_bus.valid)
            begin
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        idle_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int p;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sample_bus.valid   = 1'b0;
        sample_bus.accel_y = '0;
        sample_bus.accel_z = '0;
        sample_bus.gyro_y  = '0;
        sample_bus.gyro_z  = '0;
        tx_steady          = 1'b0;
        rx_steady          = 1'b0;
        drift_y            = 1;
        drift_z            = -1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the register map
        apb_access(gti_pkg::REG_STEP_GAIN, 1'b0, '0);
        apb_access(gti_pkg::REG_CURSOR_GAIN, 1'b0, '0);
        apb_access(gti_pkg::REG_CURSOR_OFFSET, 1'b0, '0);

        // directed: roll at the origin, on the axes, in every quadrant and
        // right at the +-180 seam, some with the gyro fields at their extremes
        send_sample(16'sd0, 16'sd0, 16'sd32767, -16'sd32768);
        send_sample(16'sd0, -16'sd5, -16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0, 16'sd1, -16'sd1);
        send_sample(-16'sd32768, 16'sd0, -16'sd1, 16'sd1);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767);
        send_sample(-16'sd1, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd1, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd12345, -16'sd12345);
        send_sample(-16'sd32768, 16'sd32767, -16'sd21846, 16'sd21845);
        send_sample(16'sd1, 16'sd1, 16'sd2, -16'sd2);
        send_sample(-16'sd1, 16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sd1, -16'sd1, 16'sd7, -16'sd7);

        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: set_registers(16'hFFFF, 8'hFF, 12'hFFF);
                1: set_registers(16'h0000, 8'h00, 12'h000);
                2: set_registers(16'h0001, 8'h01, 12'hFFF);
                3: set_registers(16'hFFFF, 8'hFF, 12'h000);
                5: set_registers(16'h8000, 8'h80, 12'h800);
                7: set_registers(16'd5123, 8'd70, 12'd750);
                default: set_registers(16'($urandom), 8'($urandom), 12'($urandom));
            endcase
            if (p == 2)
            begin
                // unit gain: increments of exactly minus one half and just
                // under plus one half must both round to zero
                send_sample(16'sd100, 16'sd100, -16'sd32768, 16'sd32767);
                send_sample(-16'sd100, 16'sd100, 16'sd32767, -16'sd32767);
            end
            repeat (PHASE_ITEMS) random_sample();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
